// File: hdl/ip_pair_flow_counter_macros.svh
// assertion macros for the flow counter table
`ifndef IP_PAIR_FLOW_COUNTER_MACROS_SVH
`define IP_PAIR_FLOW_COUNTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define IPFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ipfc_pkg.sv
// shared types and constants of the flow counter table
`timescale 1ns / 1ps

package ipfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int ENTRY_IDX_W       = 7;
    localparam int ADDR_W            = 32;
    localparam int CNT_W             = 32;
    localparam int PAIRS_W           = 8;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic                   cmd;
        logic [ADDR_W-1:0]      src_addr;
        logic [ADDR_W-1:0]      dst_addr;
        logic [ENTRY_IDX_W-1:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [ADDR_W-1:0]      entry_src;
        logic [ADDR_W-1:0]      entry_dst;
        logic [CNT_W-1:0]       pair_count;
        logic                   was_new;
        logic                   dropped;
        logic                   entry_valid;
        logic [PAIRS_W-1:0]     pairs_in_use;
    } t_out_beat;

    // item walking the cell row
    typedef struct packed {
        logic                   active;
        logic                   cmd;
        logic [ADDR_W-1:0]      src;
        logic [ADDR_W-1:0]      dst;
        logic [ENTRY_IDX_W-1:0] read_index;
        logic                   found;
        logic                   fresh;
        logic [ENTRY_IDX_W-1:0] hit_idx;
        logic [ADDR_W-1:0]      hit_src;
        logic [ADDR_W-1:0]      hit_dst;
        logic [CNT_W-1:0]       hit_cnt;
    } t_token;

endpackage

// File: hdl/ipfc_cell.sv
// one table entry: compares, counts, appends, answers reads and hands the item on
`timescale 1ns / 1ps

module ipfc_cell #(
    parameter int TABLE_ENTRIES = ipfc_pkg::TABLE_ENTRIES_DEF,
    parameter int CELL_INDEX    = 0,
    localparam int USED_W       = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mode,
    input  logic [USED_W-1:0]   i_used,
    input  ipfc_pkg::t_token    i_tok,
    output ipfc_pkg::t_token    o_tok
);

    localparam logic [USED_W-1:0] MY_POS = USED_W'(CELL_INDEX);
    localparam logic [ipfc_pkg::ENTRY_IDX_W-1:0] MY_IDX =
        ipfc_pkg::ENTRY_IDX_W'(CELL_INDEX);
    localparam bit IDX_REACH = CELL_INDEX < (1 << ipfc_pkg::ENTRY_IDX_W);

    logic [ipfc_pkg::ADDR_W-1:0] r_src, n_src;
    logic [ipfc_pkg::ADDR_W-1:0] r_dst, n_dst;
    logic [ipfc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    ipfc_pkg::t_token            r_tok, n_tok;

    logic                        w_filled;
    logic                        w_append;
    logic                        w_match;
    logic [ipfc_pkg::CNT_W-1:0]  w_cnt_inc;

    always_comb begin
        w_filled  = MY_POS < i_used;
        w_append  = i_used == MY_POS;
        w_match   = w_filled &&
                    ((r_src == i_tok.src && r_dst == i_tok.dst) ||
                     (i_mode && r_src == i_tok.dst && r_dst == i_tok.src));
        w_cnt_inc = (r_cnt == ipfc_pkg::CNT_MAX) ? r_cnt : r_cnt + ipfc_pkg::CNT_W'(1);

        n_src = r_src;
        n_dst = r_dst;
        n_cnt = r_cnt;
        n_tok = i_tok;

        if (i_tok.active) begin
            if (i_tok.cmd == ipfc_pkg::CMD_RECORD) begin
                if (w_match) begin
                    n_cnt = w_cnt_inc;
                    if (!i_tok.found) begin
                        n_tok.found   = 1'b1;
                        n_tok.hit_idx = MY_IDX;
                        n_tok.hit_src = r_src;
                        n_tok.hit_dst = r_dst;
                        n_tok.hit_cnt = w_cnt_inc;
                    end
                end else if (w_append && !i_tok.found) begin
                    n_src         = i_tok.src;
                    n_dst         = i_tok.dst;
                    n_cnt         = ipfc_pkg::CNT_W'(1);
                    n_tok.found   = 1'b1;
                    n_tok.fresh   = 1'b1;
                    n_tok.hit_idx = MY_IDX;
                    n_tok.hit_src = i_tok.src;
                    n_tok.hit_dst = i_tok.dst;
                    n_tok.hit_cnt = ipfc_pkg::CNT_W'(1);
                end
            end else if (IDX_REACH && w_filled && i_tok.read_index == MY_IDX) begin
                n_tok.found   = 1'b1;
                n_tok.hit_idx = MY_IDX;
                n_tok.hit_src = r_src;
                n_tok.hit_dst = r_dst;
                n_tok.hit_cnt = r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_dst <= n_dst;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hdl/ip_pair_flow_counter.sv
// top level of the flow counter table: cell row, fill count, output stage
`timescale 1ns / 1ps
`include "ip_pair_flow_counter_macros.svh"

// channel   direction  handshake                payload
// in        input      i_in_valid / o_in_stall  i_in_beat  (t_in_beat)
// out       output     o_out_valid / i_out_stall o_out_beat (t_out_beat)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (match_both_directions)
//
// an item walks the row of TABLE_ENTRIES cells, one cell per cycle
// one item is in the row at a time; the row length sets the rate
// a finished result waits in a hold register while the output is stalled
// the input stalls while an item is in the row or a result is held
// reset is synchronous; the table contents are undefined until written

module ip_pair_flow_counter #(
    parameter int TABLE_ENTRIES = ipfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ipfc_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ipfc_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_ENTRIES);

    logic [USED_W-1:0]    r_used, n_used;
    logic                 r_mode;
    logic                 r_busy;
    logic                 r_hold_vld;
    logic                 r_out_vld;
    ipfc_pkg::t_out_beat  r_hold;
    ipfc_pkg::t_out_beat  r_out;

    ipfc_pkg::t_token     w_head;
    ipfc_pkg::t_token     w_tok [TABLE_ENTRIES+1];
    ipfc_pkg::t_token     w_end;
    ipfc_pkg::t_out_beat  w_res;
    logic [TABLE_ENTRIES-1:0] w_active;
    logic                 w_accept;
    logic                 w_take;
    logic                 w_out_free;
    logic                 w_done;
    logic                 w_cfg_ready;

    assign w_cfg_ready = 1'b1;
    assign o_cfg_ready = w_cfg_ready;
    assign o_in_stall  = r_busy || r_hold_vld;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;
    assign w_take      = r_out_vld && !i_out_stall;
    assign w_out_free  = !r_out_vld || w_take;

    always_comb begin
        w_head            = '0;
        w_head.active     = w_accept;
        w_head.cmd        = i_in_beat.cmd;
        w_head.src        = i_in_beat.src_addr;
        w_head.dst        = i_in_beat.dst_addr;
        w_head.read_index = i_in_beat.read_index;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ipfc_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .CELL_INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mode  (r_mode),
            .i_used  (r_used),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_active[g] = w_tok[g+1].active;
    end

    assign w_end  = w_tok[TABLE_ENTRIES];
    assign w_done = w_end.active;
    assign n_used = r_used + USED_W'(w_end.fresh);

    always_comb begin
        w_res              = '0;
        w_res.pairs_in_use = ipfc_pkg::PAIRS_W'(n_used);
        if (w_end.cmd == ipfc_pkg::CMD_READ) begin
            w_res.entry_index = w_end.read_index;
            w_res.entry_valid = w_end.found;
            if (w_end.found) begin
                w_res.entry_src  = w_end.hit_src;
                w_res.entry_dst  = w_end.hit_dst;
                w_res.pair_count = w_end.hit_cnt;
            end
        end else if (w_end.found) begin
            w_res.entry_index = w_end.hit_idx;
            w_res.entry_src   = w_end.hit_src;
            w_res.entry_dst   = w_end.hit_dst;
            w_res.pair_count  = w_end.hit_cnt;
            w_res.was_new     = w_end.fresh;
            w_res.entry_valid = 1'b1;
        end else begin
            w_res.dropped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_mode     <= 1'b0;
            r_busy     <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid && w_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_used <= n_used;
            end
            if (r_hold_vld && w_out_free) begin
                r_out_vld  <= 1'b1;
                r_hold_vld <= 1'b0;
            end else if (w_done && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (w_done) begin
                r_hold_vld <= 1'b1;
            end else if (w_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_hold_vld && w_out_free) begin
            r_out <= r_hold;
        end else if (w_done && w_out_free) begin
            r_out <= w_res;
        end else if (w_done) begin
            r_hold <= w_res;
        end
    end

    `IPFC_ASSERT_NOW(a_one_item_in_row, i_clk, i_rst_n, 1'b1, $onehot0(w_active), "row overlap")
    `IPFC_ASSERT_NOW(a_done_while_busy, i_clk, i_rst_n, w_done, r_busy, "exit while idle")
    `IPFC_ASSERT_NOW(a_hold_behind_out, i_clk, i_rst_n, r_hold_vld, r_out_vld, "stray hold")
    `IPFC_ASSERT_NOW(a_used_in_range, i_clk, i_rst_n, 1'b1, r_used <= USED_MAX, "overfull")
    `IPFC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_busy && w_tok[1].active, "no entry")

endmodule

// File: dv/ip_pair_flow_counter_tb.sv
// testbench for the flow counter table: queued packets checked against a table model
`timescale 1ns / 1ps

module ip_pair_flow_counter_tb;

    import ipfc_pkg::*;

    localparam int N_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int POOL_N     = 48;
    localparam int LONG_HOLD  = 600;
    localparam int HOLD_AFTER = 200;
    localparam int DRAIN      = TABLE_ENTRIES_DEF + 16;
    localparam int MAX_CYCLES = 1000000;
    localparam int MAX_PRINTS = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    // table model
    logic [ADDR_W-1:0] tab_first  [N_ENTRIES];
    logic [ADDR_W-1:0] tab_second [N_ENTRIES];
    logic [CNT_W-1:0]  tab_count  [N_ENTRIES];
    int                tab_used  = 0;
    logic              both_dirs = 1'b0;

    t_in_beat  packet_items[$];
    t_out_beat expected_reports[$];

    logic [ADDR_W-1:0] pool_src [POOL_N];
    logic [ADDR_W-1:0] pool_dst [POOL_N];

    int   items_queued = 0;
    int   items_taken  = 0;
    int   results_seen = 0;
    int   error_count  = 0;
    int   cycle_count  = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    logic calm         = 1'b0;

    int n_new = 0, n_hit = 0, n_multi = 0, n_drop = 0;
    int n_read_hit = 0, n_read_miss = 0, n_cfg = 0;

    ip_pair_flow_counter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_out_beat predict_pair_entry(input t_in_beat b);
        t_out_beat r;
        logic      found;
        int        hit;
        int        hit_count;
        int        i;
        r         = '0;
        found     = 1'b0;
        hit       = 0;
        hit_count = 0;
        if (b.cmd == CMD_READ) begin
            r.entry_index = b.read_index;
            if (int'(b.read_index) < tab_used) begin
                r.entry_src   = tab_first[b.read_index];
                r.entry_dst   = tab_second[b.read_index];
                r.pair_count  = tab_count[b.read_index];
                r.entry_valid = 1'b1;
                n_read_hit++;
            end else begin
                n_read_miss++;
            end
        end else begin
            for (i = 0; i < tab_used; i++) begin
                if ((tab_first[i] == b.src_addr && tab_second[i] == b.dst_addr) ||
                    (both_dirs && tab_first[i] == b.dst_addr &&
                     tab_second[i] == b.src_addr)) begin
                    if (tab_count[i] != CNT_MAX) begin
                        tab_count[i] = tab_count[i] + CNT_W'(1);
                    end
                    if (!found) begin
                        found = 1'b1;
                        hit   = i;
                    end
                    hit_count++;
                end
            end
            if (found) begin
                r.entry_index = ENTRY_IDX_W'(hit);
                r.entry_src   = tab_first[hit];
                r.entry_dst   = tab_second[hit];
                r.pair_count  = tab_count[hit];
                r.entry_valid = 1'b1;
                n_hit++;
                if (hit_count > 1) begin
                    n_multi++;
                end
            end else if (tab_used >= N_ENTRIES) begin
                r.dropped = 1'b1;
                n_drop++;
            end else begin
                tab_first[tab_used]  = b.src_addr;
                tab_second[tab_used] = b.dst_addr;
                tab_count[tab_used]  = 1;
                r.entry_index        = ENTRY_IDX_W'(tab_used);
                r.entry_src          = b.src_addr;
                r.entry_dst          = b.dst_addr;
                r.pair_count         = 1;
                r.was_new            = 1'b1;
                r.entry_valid        = 1'b1;
                tab_used++;
                n_new++;
            end
        end
        r.pairs_in_use = PAIRS_W'(tab_used);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("mismatch: %s", msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("result %0d %s got %h expected %h",
                                    results_seen, name, got, want));
        end
    endtask

    task automatic check_report(input t_out_beat got, input t_out_beat want);
        compare_field("entry_index", 32'(got.entry_index), 32'(want.entry_index));
        compare_field("entry_src", got.entry_src, want.entry_src);
        compare_field("entry_dst", got.entry_dst, want.entry_dst);
        compare_field("pair_count", got.pair_count, want.pair_count);
        compare_field("was_new", 32'(got.was_new), 32'(want.was_new));
        compare_field("dropped", 32'(got.dropped), 32'(want.dropped));
        compare_field("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
        compare_field("pairs_in_use", 32'(got.pairs_in_use), 32'(want.pairs_in_use));
    endtask

    task automatic queue_record(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] d);
        t_in_beat b;
        b            = '0;
        b.cmd        = CMD_RECORD;
        b.src_addr   = s;
        b.dst_addr   = d;
        b.read_index = ENTRY_IDX_W'($urandom);
        packet_items.push_back(b);
        items_queued++;
    endtask

    task automatic queue_read(input logic [ENTRY_IDX_W-1:0] idx);
        t_in_beat b;
        b            = '0;
        b.cmd        = CMD_READ;
        b.src_addr   = $urandom;
        b.dst_addr   = $urandom;
        b.read_index = idx;
        packet_items.push_back(b);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        both_dirs = v;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int pct_read, input int pct_fresh);
        int r;
        int k;
        int j;
        for (j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < pct_read) begin
                if ($urandom_range(0, 1) == 0) begin
                    queue_read(ENTRY_IDX_W'($urandom_range(0, 127)));
                end else begin
                    queue_read(ENTRY_IDX_W'($urandom_range(0, 40)));
                end
            end else if (r < pct_read + pct_fresh) begin
                queue_record($urandom, $urandom);
            end else begin
                k = $urandom_range(0, POOL_N - 1);
                if ($urandom_range(0, 3) == 0) begin
                    queue_record(pool_dst[k], pool_src[k]);
                end else begin
                    queue_record(pool_src[k], pool_dst[k]);
                end
            end
        end
    endtask

    // packet sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_reports.push_back(predict_pair_entry(in_beat));
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (packet_items.size() != 0) begin
                    in_beat  <= packet_items.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure, with one long hold to fill the block
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing expected: %p",
                                        results_seen, out_beat));
            end else begin
                check_report(out_beat, expected_reports.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_reports.size());
            $display("ip_pair_flow_counter_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        // empty table, same address twice, extremes, reversed pair as its own entry
        queue_read(7'd0);
        queue_read(7'd127);
        queue_record(32'h0000_0000, 32'h0000_0000);
        queue_record(32'h0000_0000, 32'h0000_0000);
        queue_record(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_record(32'h0000_0000, 32'hFFFF_FFFF);
        queue_record(32'hFFFF_FFFF, 32'h0000_0000);
        queue_record(32'h0000_0000, 32'hFFFF_FFFF);
        queue_record(32'hC0A8_0001, 32'h0A00_0001);
        queue_record(32'h0A00_0001, 32'hC0A8_0001);
        queue_read(7'd0);
        queue_read(7'd4);
        queue_read(7'd5);
        queue_read(7'd6);
        queue_read(7'd127);
        wait_idle();

        // both directions: several matches, swapped hits
        write_mode(1'b1);
        queue_record(32'hC0A8_0001, 32'h0A00_0001);
        queue_record(32'h0A00_0001, 32'hC0A8_0001);
        queue_record(32'hFFFF_FFFF, 32'h0000_0000);
        queue_record(32'h0000_0000, 32'h0000_0000);
        queue_record(32'h1234_5678, 32'h9ABC_DEF0);
        queue_record(32'h9ABC_DEF0, 32'h1234_5678);
        queue_read(7'd4);
        queue_read(7'd6);
        queue_read(7'd7);
        wait_idle();

        for (k = 0; k < POOL_N; k++) begin
            pool_src[k] = $urandom;
            pool_dst[k] = (k % 8 == 0) ? pool_src[k] : $urandom;
        end

        write_mode(1'b0);
        random_phase(400, 20, 5);
        wait_idle();
        write_mode(1'b1);
        random_phase(400, 20, 5);
        wait_idle();
        write_mode(1'b0);
        random_phase(400, 25, 20);
        wait_idle();
        calm = 1'b1;
        write_mode(1'b1);
        random_phase(500, 25, 10);
        wait_idle();
        repeat (DRAIN) @(posedge clk);

        $display("records: %0d new, %0d hits (%0d on several entries), %0d dropped when full",
                 n_new, n_hit, n_multi, n_drop);
        $display("reads: %0d filled, %0d beyond use; %0d mode writes; %0d results checked",
                 n_read_hit, n_read_miss, n_cfg, results_seen);
        if (error_count == 0) begin
            $display("ip_pair_flow_counter_tb OK");
        end else begin
            $display("ip_pair_flow_counter_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/ipfc_pkg.sv
hdl/ipfc_cell.sv
hdl/ip_pair_flow_counter.sv
dv/ip_pair_flow_counter_tb.sv
